// File: rtl/nttls_pkg.sv
// ----------------------------------------------------------------------------
// nttls_pkg
// Shared types, sizes and codes of the negacyclic NTT block with Shoup
// lazy reduction.
// ----------------------------------------------------------------------------
package nttls_pkg;

	// Transform size; must be a power of two, at least 8.
	localparam int POINTS     = 1024;
	localparam int LOG_POINTS = $clog2(POINTS);
	localparam int IDX_W      = LOG_POINTS;
	localparam int BF_W       = LOG_POINTS - 1;
	localparam int STG_W      = $clog2(LOG_POINTS);

	localparam int KIND_W  = 2;
	localparam int SLOT_W  = 10;
	localparam int WORD_W  = 64;
	localparam int MOD_W   = 62;
	localparam int CIDX_W  = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_WR_COEFF   = 2'd0,
		KIND_WR_TWIDDLE = 2'd1,
		KIND_RUN        = 2'd2,
		KIND_RD_COEFF   = 2'd3
	} kind_t;

	typedef enum logic {
		TAG_DONE = 1'b0,
		TAG_READ = 1'b1
	} tag_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_MODULUS           = 3'd0,
		REG_INVERSE_MODE      = 3'd1,
		REG_INV_DEGREE        = 3'd2,
		REG_INV_DEGREE_SHOUP  = 3'd3,
		REG_MONT_FACTOR       = 3'd4,
		REG_MONT_FACTOR_SHOUP = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_ISSUE,
		ST_LOAD,
		ST_MUL1,
		ST_MUL2,
		ST_WA,
		ST_WB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] word_shoup;
	} in_word_t;

	typedef struct packed {
		logic              tag;
		logic [WORD_W-1:0] read_data;
	} out_word_t;

endpackage

// File: rtl/negacyclic_ntt_lazy_shoup_top.sv
// ----------------------------------------------------------------------------
// negacyclic_ntt_lazy_shoup_top
// In-place negacyclic NTT over a coefficient memory and a twiddle memory,
// with Shoup lazy reduction on 64-bit words.
// ----------------------------------------------------------------------------
// Words on the input channel load a coefficient, load a twiddle pair (value
// and Shoup companion), run the transform in place, or read a coefficient
// back. A coefficient or twiddle load gives no result. A read latches the
// coefficient and returns it as a registered read word from ST_READ. A run
// goes through log2(N) stages of N/2 butterflies; each butterfly reads both
// coefficients and the twiddle together, runs through the Shoup multiplier
// (a single 32x32 multiplier stepped through twelve partial products) and
// writes its two results back in ST_WA and ST_WB; a butterfly of the last
// stage needs two Shoup products. At its end a run returns one word with
// tag 0 and read_data 0. Forward mode scales the even inputs of the last
// stage by mont_factor; inverse mode scales x0 + x1 of its last stage by
// inv_degree. Stores are not cleared at reset: only entries that have been
// written may be read or transformed. Configuration writes are taken at
// any time but must only be made while the block is idle.
// ----------------------------------------------------------------------------
module negacyclic_ntt_lazy_shoup_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  nttls_pkg::in_word_t          in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output nttls_pkg::out_word_t         out_data,
	input  logic                         cfg_we,
	input  logic [nttls_pkg::CIDX_W-1:0] cfg_index,
	input  logic [nttls_pkg::WORD_W-1:0] cfg_wdata
);
	import nttls_pkg::*;

	// Configuration registers.
	logic [MOD_W-1:0]  modulus_q, inv_degree_q, mont_factor_q;
	logic [WORD_W-1:0] inv_degree_shoup_q, mont_factor_shoup_q;
	logic              inverse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q           <= MOD_W'(3);
			inverse_q           <= 1'b0;
			inv_degree_q        <= '0;
			inv_degree_shoup_q  <= '0;
			mont_factor_q       <= '0;
			mont_factor_shoup_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODULUS:           modulus_q           <= cfg_wdata[MOD_W-1:0];
				REG_INVERSE_MODE:      inverse_q           <= cfg_wdata[0];
				REG_INV_DEGREE:        inv_degree_q        <= cfg_wdata[MOD_W-1:0];
				REG_INV_DEGREE_SHOUP:  inv_degree_shoup_q  <= cfg_wdata;
				REG_MONT_FACTOR:       mont_factor_q       <= cfg_wdata[MOD_W-1:0];
				REG_MONT_FACTOR_SHOUP: mont_factor_shoup_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Control state.
	state_t            state_q, state_d;
	logic [STG_W-1:0]  stage_q;
	logic [BF_W-1:0]   bf_q;
	logic              inside_q;
	logic              out_valid_q;
	out_word_t         out_data_q;

	logic              accept, slot_inside, is_write;
	logic              last_stage, last_bf;
	logic [STG_W-1:0]  k;
	logic [IDX_W-1:0]  jx, lo_mask, a_idx, b_idx, grp, tw_idx;
	logic [IDX_W:0]    inv_base;

	assign accept      = in_valid && in_ready;
	assign slot_inside = (32'(in_data.slot) < POINTS);
	assign is_write    = (in_data.kind == KIND_WR_COEFF) || (in_data.kind == KIND_WR_TWIDDLE);
	assign last_stage  = (stage_q == STG_W'(LOG_POINTS - 1));
	assign last_bf     = (bf_q == {BF_W{1'b1}});

	// Butterfly addressing. The half-size is 2^k; the butterfly counter is
	// split into group and offset by opening a zero bit at position k.
	always_comb begin
		k        = inverse_q ? stage_q : STG_W'(LOG_POINTS - 1) - stage_q;
		jx       = IDX_W'(bf_q);
		lo_mask  = (IDX_W'(1) << k) - IDX_W'(1);
		grp      = jx >> k;
		a_idx    = (grp << (k + STG_W'(1))) | (jx & lo_mask);
		b_idx    = a_idx | (IDX_W'(1) << k);
		// Inverse stages start after all twiddles of the earlier stages.
		inv_base = (IDX_W+1)'(1) + (IDX_W+1)'(POINTS) - ((IDX_W+1)'(POINTS) >> stage_q);
		tw_idx   = inverse_q ? (IDX_W'(inv_base) + grp) : ((IDX_W'(1) << stage_q) + grp);
	end

	// Coefficient memory: two read ports, one write port.
	logic [WORD_W-1:0] coeff_mem [POINTS];
	logic [WORD_W-1:0] rda_q, rdb_q;
	logic              cm_we, cm_re;
	logic [IDX_W-1:0]  cm_waddr, cm_ra;
	logic [WORD_W-1:0] cm_wdata;

	always_ff @(posedge clk) begin
		if (cm_we) begin
			coeff_mem[cm_waddr] <= cm_wdata;
		end
		if (cm_re) begin
			rda_q <= coeff_mem[cm_ra];
			rdb_q <= coeff_mem[b_idx];
		end
	end

	// Twiddle memory: value and Shoup companion side by side.
	logic [2*WORD_W-1:0] tw_mem [POINTS];
	logic [2*WORD_W-1:0] tw_rd_q;
	logic                tw_we, tw_re;

	always_ff @(posedge clk) begin
		if (tw_we) begin
			tw_mem[IDX_W'(in_data.slot)] <= {in_data.word, in_data.word_shoup};
		end
		if (tw_re) begin
			tw_rd_q <= tw_mem[tw_idx];
		end
	end

	// Butterfly datapath.
	logic [WORD_W-1:0] two_p, sum_ab, diff_ab, ext_q, r1_q, r2_q, u0;
	logic [WORD_W-1:0] mul_x, mul_y, mul_ys, mul_res;
	logic              mul_start, mul_done;

	assign two_p   = WORD_W'({modulus_q, 1'b0});
	assign sum_ab  = rda_q + rdb_q;
	assign diff_ab = rda_q - rdb_q + two_p;
	assign u0      = last_stage ? r2_q : ext_q;

	// The first product uses the twiddle; the second scales the even side
	// of the last stage.
	always_comb begin
		if (state_q == ST_MUL1) begin
			mul_x  = inverse_q ? sum_ab : rda_q;
			mul_y  = inverse_q ? WORD_W'(inv_degree_q) : WORD_W'(mont_factor_q);
			mul_ys = inverse_q ? inv_degree_shoup_q : mont_factor_shoup_q;
		end else begin
			mul_x  = inverse_q ? diff_ab : rdb_q;
			mul_y  = tw_rd_q[2*WORD_W-1:WORD_W];
			mul_ys = tw_rd_q[WORD_W-1:0];
		end
	end

	nttls_shoup u_shoup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.ys     (mul_ys),
		.p      (modulus_q),
		.done   (mul_done),
		.res    (mul_res)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			if (inverse_q) begin
				ext_q <= (sum_ab < two_p) ? sum_ab : sum_ab - two_p;
			end else begin
				ext_q <= (rda_q < two_p) ? rda_q : rda_q - two_p;
			end
		end
		if (state_q == ST_MUL1 && mul_done) begin
			r1_q <= mul_res;
		end
		if (state_q == ST_MUL2 && mul_done) begin
			r2_q <= mul_res;
		end
	end

	// Next state and control.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cm_we     = 1'b0;
		cm_re     = 1'b0;
		cm_waddr  = a_idx;
		cm_ra     = a_idx;
		cm_wdata  = inverse_q ? u0 : u0 + r1_q;
		tw_we     = 1'b0;
		tw_re     = 1'b0;
		mul_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready || is_write;
				cm_ra    = IDX_W'(in_data.slot);
				cm_waddr = IDX_W'(in_data.slot);
				cm_wdata = in_data.word;
				if (accept) begin
					unique case (in_data.kind)
						KIND_WR_COEFF:   cm_we = slot_inside;
						KIND_WR_TWIDDLE: tw_we = slot_inside;
						KIND_RUN:        state_d = ST_ISSUE;
						KIND_RD_COEFF: begin
							cm_re   = 1'b1;
							state_d = ST_READ;
						end
						default: ;
					endcase
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_ISSUE: begin
				cm_re   = 1'b1;
				tw_re   = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				mul_start = 1'b1;
				state_d   = ST_MUL1;
			end
			ST_MUL1: begin
				if (mul_done) begin
					if (last_stage) begin
						mul_start = 1'b1;
						state_d   = ST_MUL2;
					end else begin
						state_d = ST_WA;
					end
				end
			end
			ST_MUL2: begin
				if (mul_done) begin
					state_d = ST_WA;
				end
			end
			ST_WA: begin
				cm_we   = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				cm_we    = 1'b1;
				cm_waddr = b_idx;
				cm_wdata = inverse_q ? r1_q : u0 - r1_q + two_p;
				if (last_bf && last_stage) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_ISSUE;
				end
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stage_q     <= '0;
			bf_q        <= '0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && accept) begin
				stage_q  <= '0;
				bf_q     <= '0;
				inside_q <= slot_inside;
			end
			if (state_q == ST_WB) begin
				bf_q <= bf_q + BF_W'(1);
				if (last_bf) begin
					stage_q <= stage_q + STG_W'(1);
				end
			end
			if (state_q == ST_READ || state_q == ST_DONE) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			out_data_q.tag       <= TAG_READ;
			out_data_q.read_data <= inside_q ? rda_q : '0;
		end else if (state_q == ST_DONE) begin
			out_data_q.tag       <= TAG_DONE;
			out_data_q.read_data <= '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/nttls_shoup.sv
// ----------------------------------------------------------------------------
// nttls_shoup
// Shoup modular product x*y - floor(x*ys / 2^64) * p, modulo 2^64, built on
// one 32x32 multiplier that works through twelve partial products.
// ----------------------------------------------------------------------------
module nttls_shoup (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [nttls_pkg::WORD_W-1:0] x,
	input  logic [nttls_pkg::WORD_W-1:0] y,
	input  logic [nttls_pkg::WORD_W-1:0] ys,
	input  logic [nttls_pkg::MOD_W-1:0]  p,
	output logic                      done,
	output logic [nttls_pkg::WORD_W-1:0] res
);
	import nttls_pkg::*;

	logic                busy_q;
	logic [1:0]          phase_q;
	logic [2:0]          cnt_q;
	logic [WORD_W-1:0]   opx_q, opy_q, ops_q, opp_q;
	logic [WORD_W-1:0]   q_q, xy_q, res_q;
	logic                done_q;
	logic [2*WORD_W-1:0] acc_q;
	logic [WORD_W-1:0]   prod_s1;
	logic [1:0]          sh_s1;
	logic                vld_s1;

	logic [WORD_W-1:0]   op_a, op_b;
	logic [31:0]         half_a, half_b;
	logic [2*WORD_W-1:0] shifted, acc_next;
	logic                issue;

	// Each phase issues four partial products, then a closing step (cnt_q == 4) ends it.
	assign issue = busy_q && (cnt_q < 3'd4);

	always_comb begin
		unique case (phase_q)
			2'd0:    begin op_a = opx_q; op_b = ops_q; end
			2'd1:    begin op_a = opx_q; op_b = opy_q; end
			default: begin op_a = q_q;   op_b = opp_q; end
		endcase
		half_a = cnt_q[0] ? op_a[63:32] : op_a[31:0];
		half_b = cnt_q[1] ? op_b[63:32] : op_b[31:0];
		unique case (sh_s1)
			2'd0:    shifted = {64'd0, prod_s1};
			2'd1:    shifted = {32'd0, prod_s1, 32'd0};
			default: shifted = {prod_s1, 64'd0};
		endcase
		acc_next = acc_q + (vld_s1 ? shifted : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 2'd0;
			cnt_q   <= 3'd0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issue;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 2'd0;
				cnt_q   <= 3'd0;
				acc_q   <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					acc_q <= '0;
					cnt_q <= 3'd0;
					if (phase_q == 2'd2) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end else begin
					acc_q <= acc_next;
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			opx_q <= x;
			opy_q <= y;
			ops_q <= ys;
			opp_q <= WORD_W'(p);
		end
		if (issue) begin
			prod_s1 <= WORD_W'(half_a) * WORD_W'(half_b);
			sh_s1   <= 2'(cnt_q[0]) + 2'(cnt_q[1]);
		end
		if (busy_q && cnt_q == 3'd4) begin
			unique case (phase_q)
				2'd0:    q_q   <= acc_next[2*WORD_W-1:WORD_W];
				2'd1:    xy_q  <= acc_next[WORD_W-1:0];
				default: res_q <= xy_q - acc_next[WORD_W-1:0];
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: rtl/nttls_checker.sv
// ----------------------------------------------------------------------------
// nttls_checker
// Port-level checks of the NTT block, bound to its top level.
// ----------------------------------------------------------------------------
module nttls_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  nttls_pkg::in_word_t          in_data,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  nttls_pkg::out_word_t         out_data
);
	import nttls_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// A read returns a word tagged as a read.
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_data.kind == KIND_RD_COEFF |-> ##2 (out_valid && out_data.tag == TAG_READ))
		else $error("read word missing");

	// Loads give no result.
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !out_valid &&
		(in_data.kind == KIND_WR_COEFF || in_data.kind == KIND_WR_TWIDDLE) |=> !out_valid)
		else $error("load produced a result");

	// A finished transform carries zero data.
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tag == TAG_DONE |-> out_data.read_data == '0)
		else $error("done word carries data");

endmodule

bind negacyclic_ntt_lazy_shoup_top nttls_checker u_nttls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
